>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// Constants and codes for the single-touch gesture recognizer.
// ----------------------------------------------------------------------------
package tgr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 32;

    localparam int MS_BITS   = 16;
    localparam int DIST_BITS = 13;
    localparam int SQ_BITS   = 2 * DIST_BITS;
    localparam int GEST_BITS = 4;
    localparam int IDX_BITS  = 4;
    localparam int FLAG_BITS = 3;

    typedef logic [GEST_BITS-1:0] gesture_t;
    typedef logic [IDX_BITS-1:0]  cfg_index_t;

    localparam gesture_t GEST_TAP         = 4'd0;
    localparam gesture_t GEST_DOUBLE_TAP  = 4'd1;
    localparam gesture_t GEST_LONG_PRESS  = 4'd2;
    localparam gesture_t GEST_SWIPE_UP    = 4'd3;
    localparam gesture_t GEST_SWIPE_DOWN  = 4'd4;
    localparam gesture_t GEST_SWIPE_LEFT  = 4'd5;
    localparam gesture_t GEST_SWIPE_RIGHT = 4'd6;
    localparam gesture_t GEST_DRAG_START  = 4'd7;
    localparam gesture_t GEST_DRAG_MOVE   = 4'd8;
    localparam gesture_t GEST_DRAG_END    = 4'd9;

    localparam cfg_index_t REG_DEBOUNCE_MS     = 4'd0;
    localparam cfg_index_t REG_LONG_PRESS_MS   = 4'd1;
    localparam cfg_index_t REG_TAP_MAX_DIST    = 4'd2;
    localparam cfg_index_t REG_DRAG_MIN_DIST   = 4'd3;
    localparam cfg_index_t REG_SWIPE_MIN_DIST  = 4'd4;
    localparam cfg_index_t REG_SWIPE_MAX_MS    = 4'd5;
    localparam cfg_index_t REG_DOUBLE_TAP_MS   = 4'd6;
    localparam cfg_index_t REG_DOUBLE_TAP_DIST = 4'd7;

    localparam logic [MS_BITS-1:0] DEBOUNCE_MS_RST   = 16'd50;
    localparam logic [MS_BITS-1:0] LONG_PRESS_MS_RST = 16'd500;
    localparam logic [MS_BITS-1:0] SWIPE_MAX_MS_RST  = 16'd300;
    localparam logic [MS_BITS-1:0] DOUBLE_TAP_MS_RST = 16'd300;

    localparam logic [SQ_BITS-1:0] TAP_MAX_SQ_RST    = 26'd400;
    localparam logic [SQ_BITS-1:0] DRAG_MIN_SQ_RST   = 26'd900;
    localparam logic [SQ_BITS-1:0] SWIPE_MIN_SQ_RST  = 26'd2500;
    localparam logic [SQ_BITS-1:0] DOUBLE_TAP_SQ_RST = 26'd1600;

endpackage

>>> hdl/touch_gesture_recognizer.sv
// ----------------------------------------------------------------------------
// touch_gesture_recognizer
// Single-touch gesture recognizer: tap, double tap, long press, swipes, drag.
// ----------------------------------------------------------------------------
// A sample goes through the input register and then the result register;
// m_tvalid rises only for a sample that yields a gesture. Throughput: 1
// sample per cycle while results drain; input register, one combinational pass
// over the touch state and squared-distance compares, then a result register.
// Reset: async, active low; clears touch state, pending tap, valid flags and
// loads the default thresholds.
module touch_gesture_recognizer #(
    parameter int COORD_BITS = tgr_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = tgr_pkg::TIME_BITS_DEF,
    localparam int IN_RAW_W   = 2 * COORD_BITS + TIME_BITS,
    localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8,
    localparam int OUT_RAW_W  = 4 * COORD_BITS + 2 * (COORD_BITS + 1) + 2 * TIME_BITS,
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x, pos_y, time_ms
    input  logic [IN_DATA_W-1:0]            s_tdata,
    // press_edge, held, release_edge
    input  logic [tgr_pkg::FLAG_BITS-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // end_x, end_y, begin_x, begin_y, move_x, move_y, hold_ms, event_ms
    output logic [OUT_DATA_W-1:0]           m_tdata,
    // gesture
    output logic [tgr_pkg::GEST_BITS-1:0]   m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tgr_pkg::IDX_BITS-1:0]    cfg_index,
    input  logic [tgr_pkg::MS_BITS-1:0]     cfg_data
);

    localparam int C   = COORD_BITS;
    localparam int T   = TIME_BITS;
    localparam int D2W = (2 * C + 1 > tgr_pkg::SQ_BITS) ? 2 * C + 1 : tgr_pkg::SQ_BITS;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_LONG = 2'd2;
    localparam logic [1:0] PH_DRAG = 2'd3;

    // configuration
    logic [tgr_pkg::MS_BITS-1:0] debounce_reg, long_press_reg, swipe_max_reg, dtap_ms_reg;
    logic [tgr_pkg::SQ_BITS-1:0] tap_sq_reg, drag_sq_reg, swipe_sq_reg, dtap_sq_reg;
    logic [tgr_pkg::DIST_BITS-1:0] cfg_dist;
    logic [tgr_pkg::SQ_BITS-1:0]   cfg_sq;

    // input register
    logic          in_valid_reg;
    logic          press_reg, held_reg, rel_reg;
    logic [C-1:0]  x_reg, y_reg;
    logic [T-1:0]  ts_reg;
    logic          fire;

    // touch state
    logic [1:0]    phase_reg, phase_next;
    logic [C-1:0]  start_x_reg, start_x_next, start_y_reg, start_y_next;
    logic [T-1:0]  start_time_reg, start_time_next;
    logic [C-1:0]  ref_x_reg, ref_x_next, ref_y_reg, ref_y_next;
    logic          tap_pend_reg, tap_pend_next;
    logic [C-1:0]  tap_x_reg, tap_x_next, tap_y_reg, tap_y_next;
    logic [T-1:0]  tap_time_reg, tap_time_next;
    logic [T-1:0]  last_ev_reg, last_ev_next;

    // result
    logic                   out_valid_reg;
    tgr_pkg::gesture_t      g_reg, g_next;
    logic [C-1:0]           ex_reg, ex_next, ey_reg, ey_next;
    logic [C-1:0]           bx_reg, bx_next, by_reg, by_next;
    logic signed [C:0]      mvx_reg, mvx_next, mvy_reg, mvy_next;
    logic [T-1:0]           hold_reg, hold_next, evt_reg, evt_next;
    logic                   emit;

    // datapath
    logic signed [C:0] sx, sy, mx, my, tx, ty;
    logic [C-1:0]      ax, ay;
    logic [D2W-1:0]    d2_start, d2_tap;
    logic [T-1:0]      dur, since_ev, gap;
    logic              is_long, is_drag, is_swipe, is_tap, is_dtap;

    assign cfg_ready = 1'b1;
    assign cfg_dist  = cfg_data[tgr_pkg::DIST_BITS-1:0];
    assign cfg_sq    = {{tgr_pkg::DIST_BITS{1'b0}}, cfg_dist}
                     * {{tgr_pkg::DIST_BITS{1'b0}}, cfg_dist};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= tgr_pkg::DEBOUNCE_MS_RST;
            long_press_reg <= tgr_pkg::LONG_PRESS_MS_RST;
            swipe_max_reg  <= tgr_pkg::SWIPE_MAX_MS_RST;
            dtap_ms_reg    <= tgr_pkg::DOUBLE_TAP_MS_RST;
            tap_sq_reg     <= tgr_pkg::TAP_MAX_SQ_RST;
            drag_sq_reg    <= tgr_pkg::DRAG_MIN_SQ_RST;
            swipe_sq_reg   <= tgr_pkg::SWIPE_MIN_SQ_RST;
            dtap_sq_reg    <= tgr_pkg::DOUBLE_TAP_SQ_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tgr_pkg::REG_DEBOUNCE_MS:     debounce_reg   <= cfg_data;
                tgr_pkg::REG_LONG_PRESS_MS:   long_press_reg <= cfg_data;
                tgr_pkg::REG_TAP_MAX_DIST:    tap_sq_reg     <= cfg_sq;
                tgr_pkg::REG_DRAG_MIN_DIST:   drag_sq_reg    <= cfg_sq;
                tgr_pkg::REG_SWIPE_MIN_DIST:  swipe_sq_reg   <= cfg_sq;
                tgr_pkg::REG_SWIPE_MAX_MS:    swipe_max_reg  <= cfg_data;
                tgr_pkg::REG_DOUBLE_TAP_MS:   dtap_ms_reg    <= cfg_data;
                tgr_pkg::REG_DOUBLE_TAP_DIST: dtap_sq_reg    <= cfg_sq;
                default:                      ;
            endcase
        end
    end

    // advance when the result register is free or being drained
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            press_reg <= s_tuser[0];
            held_reg  <= s_tuser[1];
            rel_reg   <= s_tuser[2];
            x_reg     <= s_tdata[C-1:0];
            y_reg     <= s_tdata[2*C-1:C];
            ts_reg    <= s_tdata[2*C+T-1:2*C];
        end
    end

    always_comb
    begin
        sx       = $signed({1'b0, x_reg}) - $signed({1'b0, start_x_reg});
        sy       = $signed({1'b0, y_reg}) - $signed({1'b0, start_y_reg});
        mx       = $signed({1'b0, x_reg}) - $signed({1'b0, ref_x_reg});
        my       = $signed({1'b0, y_reg}) - $signed({1'b0, ref_y_reg});
        tx       = $signed({1'b0, x_reg}) - $signed({1'b0, tap_x_reg});
        ty       = $signed({1'b0, y_reg}) - $signed({1'b0, tap_y_reg});
        ax       = sx[C] ? C'(-sx) : sx[C-1:0];
        ay       = sy[C] ? C'(-sy) : sy[C-1:0];
        d2_start = D2W'($unsigned(D2W'(sx * sx))) + D2W'($unsigned(D2W'(sy * sy)));
        d2_tap   = D2W'($unsigned(D2W'(tx * tx))) + D2W'($unsigned(D2W'(ty * ty)));
        dur      = ts_reg - start_time_reg;
        since_ev = ts_reg - last_ev_reg;
        gap      = ts_reg - tap_time_reg;
        is_long  = (dur >= T'(long_press_reg)) && (d2_start < D2W'(tap_sq_reg));
        is_drag  = (d2_start >= D2W'(drag_sq_reg)) && (dur > T'(swipe_max_reg));
        is_swipe = (d2_start >= D2W'(swipe_sq_reg)) && (dur <= T'(swipe_max_reg));
        is_tap   = d2_start < D2W'(tap_sq_reg);
        is_dtap  = (gap < T'(dtap_ms_reg)) && (d2_tap < D2W'(dtap_sq_reg));
    end

    always_comb
    begin
        phase_next      = phase_reg;
        start_x_next    = start_x_reg;
        start_y_next    = start_y_reg;
        start_time_next = start_time_reg;
        ref_x_next      = ref_x_reg;
        ref_y_next      = ref_y_reg;
        tap_pend_next   = tap_pend_reg;
        tap_x_next      = tap_x_reg;
        tap_y_next      = tap_y_reg;
        tap_time_next   = tap_time_reg;
        last_ev_next    = last_ev_reg;
        emit            = 1'b0;
        g_next          = tgr_pkg::GEST_TAP;
        ex_next         = x_reg;
        ey_next         = y_reg;
        bx_next         = start_x_reg;
        by_next         = start_y_reg;
        mvx_next        = '0;
        mvy_next        = '0;
        hold_next       = '0;
        evt_next        = ts_reg;

        priority if (press_reg)
        begin
            if (since_ev >= T'(debounce_reg))
            begin
                start_x_next    = x_reg;
                start_y_next    = y_reg;
                start_time_next = ts_reg;
                ref_x_next      = x_reg;
                ref_y_next      = y_reg;
                phase_next      = PH_WAIT;
            end
        end
        else if (held_reg)
        begin
            if (phase_reg == PH_WAIT)
            begin
                priority if (is_long)
                begin
                    phase_next = PH_LONG;
                    emit       = 1'b1;
                    g_next     = tgr_pkg::GEST_LONG_PRESS;
                    hold_next  = dur;
                end
                else if (is_drag)
                begin
                    phase_next = PH_DRAG;
                    ref_x_next = x_reg;
                    ref_y_next = y_reg;
                    emit       = 1'b1;
                    g_next     = tgr_pkg::GEST_DRAG_START;
                    mvx_next   = sx;
                    mvy_next   = sy;
                end
                else
                begin
                end
            end
            else if (phase_reg == PH_DRAG)
            begin
                ref_x_next = x_reg;
                ref_y_next = y_reg;
                emit       = 1'b1;
                g_next     = tgr_pkg::GEST_DRAG_MOVE;
                mvx_next   = mx;
                mvy_next   = my;
            end
        end
        else if (rel_reg)
        begin
            if (phase_reg != PH_IDLE)
            begin
                last_ev_next = ts_reg;
                phase_next   = PH_IDLE;
                priority if (phase_reg == PH_DRAG)
                begin
                    emit      = 1'b1;
                    g_next    = tgr_pkg::GEST_DRAG_END;
                    mvx_next  = sx;
                    mvy_next  = sy;
                    hold_next = dur;
                end
                else if (phase_reg == PH_LONG)
                begin
                end
                else if (is_swipe)
                begin
                    emit      = 1'b1;
                    mvx_next  = sx;
                    mvy_next  = sy;
                    hold_next = dur;
                    if (ax > ay)
                        g_next = sx[C] ? tgr_pkg::GEST_SWIPE_LEFT : tgr_pkg::GEST_SWIPE_RIGHT;
                    else
                        g_next = (!sy[C] && sy != '0) ? tgr_pkg::GEST_SWIPE_DOWN
                                                      : tgr_pkg::GEST_SWIPE_UP;
                end
                else if (is_drag)
                begin
                end
                else if (is_tap)
                begin
                    if (tap_pend_reg && is_dtap)
                    begin
                        tap_pend_next = 1'b0;
                        emit          = 1'b1;
                        g_next        = tgr_pkg::GEST_DOUBLE_TAP;
                        bx_next       = x_reg;
                        by_next       = y_reg;
                    end
                    else
                    begin
                        // flush the old tap, hold the new one
                        emit          = tap_pend_reg;
                        g_next        = tgr_pkg::GEST_TAP;
                        ex_next       = tap_x_reg;
                        ey_next       = tap_y_reg;
                        bx_next       = tap_x_reg;
                        by_next       = tap_y_reg;
                        evt_next      = tap_time_reg;
                        tap_x_next    = x_reg;
                        tap_y_next    = y_reg;
                        tap_time_next = ts_reg;
                        tap_pend_next = 1'b1;
                    end
                end
                else
                begin
                end
            end
        end
        else
        begin
            if (tap_pend_reg && (gap > T'(dtap_ms_reg)))
            begin
                tap_pend_next = 1'b0;
                emit          = 1'b1;
                g_next        = tgr_pkg::GEST_TAP;
                ex_next       = tap_x_reg;
                ey_next       = tap_y_reg;
                bx_next       = tap_x_reg;
                by_next       = tap_y_reg;
                evt_next      = tap_time_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            start_x_reg    <= '0;
            start_y_reg    <= '0;
            start_time_reg <= '0;
            ref_x_reg      <= '0;
            ref_y_reg      <= '0;
            tap_pend_reg   <= 1'b0;
            tap_x_reg      <= '0;
            tap_y_reg      <= '0;
            tap_time_reg   <= '0;
            last_ev_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            start_x_reg    <= start_x_next;
            start_y_reg    <= start_y_next;
            start_time_reg <= start_time_next;
            ref_x_reg      <= ref_x_next;
            ref_y_reg      <= ref_y_next;
            tap_pend_reg   <= tap_pend_next;
            tap_x_reg      <= tap_x_next;
            tap_y_reg      <= tap_y_next;
            tap_time_reg   <= tap_time_next;
            last_ev_reg    <= last_ev_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            g_reg    <= g_next;
            ex_reg   <= ex_next;
            ey_reg   <= ey_next;
            bx_reg   <= bx_next;
            by_reg   <= by_next;
            mvx_reg  <= mvx_next;
            mvy_reg  <= mvy_next;
            hold_reg <= hold_next;
            evt_reg  <= evt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = g_reg;
    assign m_tdata  = OUT_DATA_W'({evt_reg, hold_reg, mvy_reg, mvx_reg,
                                   by_reg, bx_reg, ey_reg, ex_reg});

endmodule

>>> hdl/tgr_checker.sv
// ----------------------------------------------------------------------------
// tgr_checker
// Port-level checks for the touch gesture recognizer result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tgr_checker #(
    parameter int COORD_BITS = tgr_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = tgr_pkg::TIME_BITS_DEF,
    localparam int OUT_RAW_W  = 4 * COORD_BITS + 2 * (COORD_BITS + 1) + 2 * TIME_BITS,
    localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [OUT_DATA_W-1:0]         m_tdata,
    input  logic [tgr_pkg::GEST_BITS-1:0] m_tuser
);

    localparam int C = COORD_BITS;
    localparam int T = TIME_BITS;

    logic [C-1:0] end_x, end_y, begin_x, begin_y;
    logic [C:0]   move_x, move_y;
    logic [T-1:0] hold_ms;
    logic         still_kind, tap_kind;

    assign end_x      = m_tdata[C-1:0];
    assign end_y      = m_tdata[2*C-1:C];
    assign begin_x    = m_tdata[3*C-1:2*C];
    assign begin_y    = m_tdata[4*C-1:3*C];
    assign move_x     = m_tdata[5*C:4*C];
    assign move_y     = m_tdata[6*C+1:5*C+1];
    assign hold_ms    = m_tdata[6*C+2+T-1:6*C+2];
    assign tap_kind   = (m_tuser == tgr_pkg::GEST_TAP) || (m_tuser == tgr_pkg::GEST_DOUBLE_TAP);
    assign still_kind = tap_kind || (m_tuser == tgr_pkg::GEST_LONG_PRESS);

    `ASSERT_NEXT(a_stall_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `ASSERT_IMPLIES(a_code_range, clk, rst_n, m_tvalid, m_tuser <= tgr_pkg::GEST_DRAG_END)
    `ASSERT_IMPLIES(a_still_no_move, clk, rst_n, m_tvalid && still_kind,
        move_x == '0 && move_y == '0)
    `ASSERT_IMPLIES(a_tap_point, clk, rst_n, m_tvalid && tap_kind,
        hold_ms == '0 && begin_x == end_x && begin_y == end_y)

endmodule

bind touch_gesture_recognizer tgr_checker #(
    .COORD_BITS (COORD_BITS),
    .TIME_BITS  (TIME_BITS)
) u_tgr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> verif/touch_gesture_recognizer_tb.sv
// ----------------------------------------------------------------------------
// touch_gesture_recognizer_tb
// Streams touch samples into the gesture recognizer with random gaps and
// random result back-pressure. A behavioral copy of the touch state predicts
// every gesture event, and each event is checked field by field. The run
// covers directed gestures, register extremes, random settings and timestamp
// wrap.
// ----------------------------------------------------------------------------
module touch_gesture_recognizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = tgr_pkg::COORD_BITS_DEF;
    localparam int TW          = tgr_pkg::TIME_BITS_DEF;
    localparam int DW          = tgr_pkg::DIST_BITS;
    localparam int IN_W        = ((2 * CW + TW + 7) / 8) * 8;
    localparam int OUT_W       = ((4 * CW + 2 * (CW + 1) + 2 * TW + 7) / 8) * 8;
    localparam int MX_LSB      = 4 * CW;
    localparam int MY_LSB      = 5 * CW + 1;
    localparam int HOLD_LSB    = 6 * CW + 2;
    localparam int EVT_LSB     = HOLD_LSB + TW;
    localparam int COORD_MAX   = (1 << CW) - 1;
    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 50;

    localparam tgr_pkg::cfg_index_t REG_SPARE_LO = 4'd8;
    localparam tgr_pkg::cfg_index_t REG_SPARE_HI = 4'd15;

    localparam logic [DW-1:0] TAP_DIST_RST        = 13'd20;
    localparam logic [DW-1:0] DRAG_DIST_RST       = 13'd30;
    localparam logic [DW-1:0] SWIPE_DIST_RST      = 13'd50;
    localparam logic [DW-1:0] DOUBLE_TAP_DIST_RST = 13'd40;

    typedef enum logic [1:0] {TOUCH_IDLE, TOUCH_WAIT, TOUCH_LONG, TOUCH_DRAG} touch_phase_t;
    typedef enum {SHAPE_TAP, SHAPE_HOLD, SHAPE_SWIPE, SHAPE_DRAG, SHAPE_NOISE} touch_shape_t;

    typedef struct {
        tgr_pkg::gesture_t gesture;
        logic [CW-1:0]     end_x;
        logic [CW-1:0]     end_y;
        logic [CW-1:0]     begin_x;
        logic [CW-1:0]     begin_y;
        logic [CW:0]       move_x;
        logic [CW:0]       move_y;
        logic [TW-1:0]     hold_ms;
        logic [TW-1:0]     event_ms;
    } gesture_event_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    // pos_x, pos_y, time_ms
    logic [IN_W-1:0]               s_tdata;
    // press_edge, held, release_edge
    logic [tgr_pkg::FLAG_BITS-1:0] s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    // end_x, end_y, begin_x, begin_y, move_x, move_y, hold_ms, event_ms
    logic [OUT_W-1:0]              m_tdata;
    // gesture
    logic [tgr_pkg::GEST_BITS-1:0] m_tuser;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tgr_pkg::IDX_BITS-1:0]  cfg_index;
    logic [tgr_pkg::MS_BITS-1:0]   cfg_data;

    touch_gesture_recognizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    touch_phase_t                touch_phase;
    logic [CW-1:0]               press_x, press_y, drag_x, drag_y, tap_x, tap_y;
    logic [TW-1:0]               press_ms, tap_ms, last_event_ms;
    logic                        tap_waiting;
    logic [tgr_pkg::MS_BITS-1:0] lim_debounce, lim_long, lim_swipe_ms, lim_dtap_ms;
    logic [DW-1:0]               lim_tap, lim_drag, lim_swipe, lim_dtap;

    gesture_event_t expected_gestures[$];
    gesture_event_t want;

    int            error_count;
    int            cycle_count;
    int            samples_sent;
    int            events_seen;
    int            reg_writes;
    int            settings_used;
    logic [TW-1:0] now_ms;
    int            prev_x, prev_y;
    bit            send_idle_on;
    bit            recv_idle_on;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, expected_gestures.size());
            $display("touch_gesture_recognizer_tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [TW-1:0] got, logic [TW-1:0] exp);
        if (got !== exp)
            report_mismatch($sformatf("event %0d %s: got 0x%0h, expected 0x%0h",
                                      events_seen, name, got, exp));
    endtask

    function automatic longint sq(logic [DW-1:0] v);
        return longint'(v) * longint'(v);
    endfunction

    function automatic longint span_sq(logic [CW-1:0] ax, ay, bx, by);
        longint dx, dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    function automatic void push_event(tgr_pkg::gesture_t g, logic [CW-1:0] ex, ey, bx, by,
                                       longint mx, my, logic [TW-1:0] hold, stamp);
        gesture_event_t ev;
        ev.gesture  = g;
        ev.end_x    = ex;
        ev.end_y    = ey;
        ev.begin_x  = bx;
        ev.begin_y  = by;
        ev.move_x   = mx[CW:0];
        ev.move_y   = my[CW:0];
        ev.hold_ms  = hold;
        ev.event_ms = stamp;
        expected_gestures.push_back(ev);
    endfunction

    function automatic void predict_gesture(logic press, held, rel,
                                            logic [CW-1:0] x, y, logic [TW-1:0] stamp);
        logic [TW-1:0]     dur, since_last, tap_gap;
        longint            d2, sx, sy, mx, my;
        tgr_pkg::gesture_t dir;
        dur        = stamp - press_ms;
        since_last = stamp - last_event_ms;
        tap_gap    = stamp - tap_ms;
        d2         = span_sq(x, y, press_x, press_y);
        sx         = longint'(x) - longint'(press_x);
        sy         = longint'(y) - longint'(press_y);
        if (press)
        begin
            if (since_last >= lim_debounce)
            begin
                press_x     = x;
                press_y     = y;
                press_ms    = stamp;
                drag_x      = x;
                drag_y      = y;
                touch_phase = TOUCH_WAIT;
            end
        end
        else if (held)
        begin
            if (touch_phase == TOUCH_WAIT)
            begin
                if (dur >= lim_long && d2 < sq(lim_tap))
                begin
                    touch_phase = TOUCH_LONG;
                    push_event(tgr_pkg::GEST_LONG_PRESS, x, y, press_x, press_y,
                               0, 0, dur, stamp);
                end
                else if (d2 >= sq(lim_drag) && dur > lim_swipe_ms)
                begin
                    touch_phase = TOUCH_DRAG;
                    drag_x      = x;
                    drag_y      = y;
                    push_event(tgr_pkg::GEST_DRAG_START, x, y, press_x, press_y,
                               sx, sy, 0, stamp);
                end
            end
            else if (touch_phase == TOUCH_DRAG)
            begin
                mx     = longint'(x) - longint'(drag_x);
                my     = longint'(y) - longint'(drag_y);
                drag_x = x;
                drag_y = y;
                push_event(tgr_pkg::GEST_DRAG_MOVE, x, y, press_x, press_y, mx, my, 0, stamp);
            end
        end
        else if (rel)
        begin
            if (touch_phase != TOUCH_IDLE)
            begin
                last_event_ms = stamp;
                case (touch_phase)
                    TOUCH_DRAG:
                        push_event(tgr_pkg::GEST_DRAG_END, x, y, press_x, press_y,
                                   sx, sy, dur, stamp);
                    TOUCH_LONG:
                        ;
                    default:
                    begin
                        if (d2 >= sq(lim_swipe) && dur <= lim_swipe_ms)
                        begin
                            if ((sx < 0 ? -sx : sx) > (sy < 0 ? -sy : sy))
                                dir = sx > 0 ? tgr_pkg::GEST_SWIPE_RIGHT
                                             : tgr_pkg::GEST_SWIPE_LEFT;
                            else
                                dir = sy > 0 ? tgr_pkg::GEST_SWIPE_DOWN
                                             : tgr_pkg::GEST_SWIPE_UP;
                            push_event(dir, x, y, press_x, press_y, sx, sy, dur, stamp);
                        end
                        else if (d2 < sq(lim_tap) &&
                                 !(d2 >= sq(lim_drag) && dur > lim_swipe_ms))
                        begin
                            if (tap_waiting && tap_gap < lim_dtap_ms &&
                                span_sq(x, y, tap_x, tap_y) < sq(lim_dtap))
                            begin
                                tap_waiting = 1'b0;
                                push_event(tgr_pkg::GEST_DOUBLE_TAP, x, y, x, y,
                                           0, 0, 0, stamp);
                            end
                            else
                            begin
                                if (tap_waiting)
                                    push_event(tgr_pkg::GEST_TAP, tap_x, tap_y, tap_x, tap_y,
                                               0, 0, 0, tap_ms);
                                tap_x       = x;
                                tap_y       = y;
                                tap_ms      = stamp;
                                tap_waiting = 1'b1;
                            end
                        end
                    end
                endcase
                touch_phase = TOUCH_IDLE;
            end
        end
        else if (tap_waiting && tap_gap > lim_dtap_ms)
        begin
            tap_waiting = 1'b0;
            push_event(tgr_pkg::GEST_TAP, tap_x, tap_y, tap_x, tap_y, 0, 0, 0, tap_ms);
        end
    endfunction

    task automatic send_sample(logic press, held, rel, int x, y, logic [TW-1:0] stamp);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {rel, held, press};
        s_tdata  <= {stamp, y[CW-1:0], x[CW-1:0]};
        do @(posedge clk); while (!s_tready);
        samples_sent++;
        predict_gesture(press, held, rel, x[CW-1:0], y[CW-1:0], stamp);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_gestures.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(tgr_pkg::cfg_index_t idx, logic [tgr_pkg::MS_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        reg_writes++;
        case (idx)
            tgr_pkg::REG_DEBOUNCE_MS:     lim_debounce = value;
            tgr_pkg::REG_LONG_PRESS_MS:   lim_long     = value;
            tgr_pkg::REG_TAP_MAX_DIST:    lim_tap      = value[DW-1:0];
            tgr_pkg::REG_DRAG_MIN_DIST:   lim_drag     = value[DW-1:0];
            tgr_pkg::REG_SWIPE_MIN_DIST:  lim_swipe    = value[DW-1:0];
            tgr_pkg::REG_SWIPE_MAX_MS:    lim_swipe_ms = value;
            tgr_pkg::REG_DOUBLE_TAP_MS:   lim_dtap_ms  = value;
            tgr_pkg::REG_DOUBLE_TAP_DIST: lim_dtap     = value[DW-1:0];
            default:                      ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(logic [tgr_pkg::MS_BITS-1:0] debounce, long_ms, tap, drag,
                                  swipe, swipe_ms, dtap_ms, dtap);
        settle();
        settings_used++;
        write_reg(tgr_pkg::REG_DEBOUNCE_MS, debounce);
        write_reg(tgr_pkg::REG_LONG_PRESS_MS, long_ms);
        write_reg(tgr_pkg::REG_TAP_MAX_DIST, tap);
        write_reg(tgr_pkg::REG_DRAG_MIN_DIST, drag);
        write_reg(tgr_pkg::REG_SWIPE_MIN_DIST, swipe);
        write_reg(tgr_pkg::REG_SWIPE_MAX_MS, swipe_ms);
        write_reg(tgr_pkg::REG_DOUBLE_TAP_MS, dtap_ms);
        write_reg(tgr_pkg::REG_DOUBLE_TAP_DIST, dtap);
    endtask

    function automatic int wander(int c, int spread);
        int v;
        v = c + int'($urandom_range(0, 2 * spread)) - spread;
        return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
    endfunction

    function automatic logic [TW-1:0] touch_step(int typical);
        case ($urandom_range(0, 24))
            0:       return $urandom;
            1:       return $urandom_range(0, 100000);
            default: return $urandom_range(0, typical);
        endcase
    endfunction

    task automatic random_touch();
        int           r, x, y, spread, n, typical;
        touch_shape_t shape;
        r     = $urandom_range(0, 9);
        shape = r < 3 ? SHAPE_TAP : r < 5 ? SHAPE_HOLD : r < 7 ? SHAPE_SWIPE :
                r < 9 ? SHAPE_DRAG : SHAPE_NOISE;
        case (shape)
            SHAPE_TAP:   spread = $urandom_range(0, 1) ? lim_tap / 2 : lim_tap + 2;
            SHAPE_HOLD:  spread = lim_tap / 3;
            SHAPE_SWIPE: spread = 2 * lim_swipe + 10;
            default:     spread = lim_drag / 2 + 10;
        endcase
        if ($urandom_range(0, 3) == 0)
            spread = $urandom_range(0, COORD_MAX);
        if ($urandom_range(0, 9) == 0)
            send_idle_on = !send_idle_on;
        if ($urandom_range(0, 9) == 0)
            recv_idle_on = !recv_idle_on;
        now_ms += ($urandom_range(0, 4) == 0) ? $urandom_range(0, 100) :
                  lim_debounce + $urandom_range(0, 350);
        if (shape == SHAPE_TAP && $urandom_range(0, 1))
        begin
            x = wander(prev_x, lim_dtap / 2);
            y = wander(prev_y, lim_dtap / 2);
        end
        else
        begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
        end
        if (shape == SHAPE_NOISE)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                now_ms += touch_step(600);
                send_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)),
                            $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                            $urandom_range(0, 3) == 0 ? $urandom : now_ms);
            end
        end
        else
        begin
            send_sample(1'b1, 1'b0, 1'b0, x, y, now_ms);
            case (shape)
                SHAPE_HOLD:
                begin
                    n       = $urandom_range(1, 4);
                    typical = lim_long / 2 + 200;
                end
                SHAPE_DRAG:
                begin
                    n       = $urandom_range(2, 8);
                    typical = lim_swipe_ms / 2 + 150;
                end
                SHAPE_SWIPE:
                begin
                    n       = $urandom_range(0, 1);
                    typical = lim_swipe_ms / 2 + 10;
                end
                default:
                begin
                    n       = 0;
                    typical = lim_dtap_ms / 2 + 50;
                end
            endcase
            repeat (n)
            begin
                now_ms += touch_step(typical);
                x = wander(x, spread);
                y = wander(y, spread);
                send_sample(1'b0, 1'b1, 1'b0, x, y, now_ms);
            end
            now_ms += touch_step(typical);
            x = wander(x, spread);
            y = wander(y, spread);
            send_sample(1'b0, 1'b0, 1'b1, x, y, now_ms);
            prev_x = x;
            prev_y = y;
        end
        if ($urandom_range(0, 2) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                now_ms += touch_step(lim_dtap_ms / 2 + 150);
                send_sample(1'b0, 1'b0, 1'b0, $urandom_range(0, COORD_MAX),
                            $urandom_range(0, COORD_MAX), now_ms);
            end
        end
    endtask

    task automatic test_random_touches(int count);
        int target;
        target = samples_sent + count;
        while (samples_sent < target)
            random_touch();
    endtask

    task automatic test_long_press_and_debounce();
        send_sample(1'b1, 1'b0, 1'b0, 100, 100, 32'd1000);
        send_sample(1'b0, 1'b1, 1'b0, 102, 101, 32'd1600);
        send_sample(1'b0, 1'b0, 1'b1, 103, 101, 32'd1650);
        send_sample(1'b0, 1'b0, 1'b1, 500, 500, 32'd1700);
        send_sample(1'b1, 1'b0, 1'b0, 200, 200, 32'd1690);
        send_sample(1'b0, 1'b1, 1'b0, 200, 200, 32'd1720);
    endtask

    task automatic test_swipes();
        send_sample(1'b1, 1'b0, 1'b0, 0, 0, 32'd2000);
        send_sample(1'b0, 1'b0, 1'b1, COORD_MAX, 0, 32'd2100);
        send_sample(1'b1, 1'b0, 1'b0, COORD_MAX, COORD_MAX, 32'd2200);
        send_sample(1'b0, 1'b0, 1'b1, 0, COORD_MAX, 32'd2250);
        send_sample(1'b1, 1'b0, 1'b0, 2000, COORD_MAX, 32'd2400);
        send_sample(1'b0, 1'b0, 1'b1, 2000, 0, 32'd2700);
        send_sample(1'b1, 1'b0, 1'b0, 2000, 0, 32'd2800);
        send_sample(1'b0, 1'b0, 1'b1, 2010, COORD_MAX, 32'd2900);
    endtask

    task automatic test_drag();
        send_sample(1'b1, 1'b0, 1'b0, 500, 500, 32'd3000);
        send_sample(1'b0, 1'b1, 1'b0, 600, 600, 32'd3400);
        send_sample(1'b0, 1'b1, 1'b0, 650, 580, 32'd3450);
        send_sample(1'b0, 1'b0, 1'b1, 700, 700, 32'd3500);
        send_sample(1'b1, 1'b0, 1'b0, 1000, 1000, 32'd3600);
        send_sample(1'b0, 1'b0, 1'b1, 1100, 1000, 32'd4000);
    endtask

    task automatic test_taps();
        send_sample(1'b1, 1'b0, 1'b0, 300, 300, 32'd4100);
        send_sample(1'b0, 1'b0, 1'b1, 305, 300, 32'd4150);
        send_sample(1'b1, 1'b0, 1'b0, 310, 300, 32'd4300);
        send_sample(1'b0, 1'b0, 1'b1, 310, 302, 32'd4350);
        send_sample(1'b1, 1'b0, 1'b0, 800, 800, 32'd4500);
        send_sample(1'b0, 1'b0, 1'b1, 800, 800, 32'd4550);
        send_sample(1'b0, 1'b0, 1'b0, 0, 0, 32'd4900);
        send_sample(1'b1, 1'b0, 1'b0, 100, 3000, 32'd5000);
        send_sample(1'b0, 1'b0, 1'b1, 100, 3000, 32'd5050);
        send_sample(1'b1, 1'b0, 1'b0, 1000, 3000, 32'd5200);
        send_sample(1'b0, 1'b0, 1'b1, 1000, 3000, 32'd5250);
    endtask

    task automatic test_spare_registers();
        settle();
        write_reg(REG_SPARE_LO, 16'($urandom));
        write_reg(REG_SPARE_HI, 16'hFFFF);
        test_random_touches(60);
    endtask

    task automatic test_random_settings(int rounds);
        repeat (rounds)
        begin
            apply_settings(16'($urandom_range(0, 200)), 16'($urandom_range(0, 1000)),
                           16'($urandom_range(0, 60)), 16'($urandom_range(0, 100)),
                           16'($urandom_range(0, 200)), 16'($urandom_range(0, 600)),
                           16'($urandom_range(0, 600)), 16'($urandom_range(0, 100)));
            test_random_touches(100);
        end
    endtask

    task automatic test_timestamp_wrap();
        apply_settings(tgr_pkg::DEBOUNCE_MS_RST, tgr_pkg::LONG_PRESS_MS_RST,
                       16'(TAP_DIST_RST), 16'(DRAG_DIST_RST), 16'(SWIPE_DIST_RST),
                       tgr_pkg::SWIPE_MAX_MS_RST, tgr_pkg::DOUBLE_TAP_MS_RST,
                       16'(DOUBLE_TAP_DIST_RST));
        now_ms = 32'hFFFF_F000;
        test_random_touches(150);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            events_seen++;
            if (expected_gestures.size() == 0)
                report_mismatch($sformatf("unexpected event, gesture %0d", m_tuser));
            else
            begin
                want = expected_gestures.pop_front();
                check_field("gesture", m_tuser, want.gesture);
                check_field("end_x", m_tdata[0 +: CW], want.end_x);
                check_field("end_y", m_tdata[CW +: CW], want.end_y);
                check_field("begin_x", m_tdata[2 * CW +: CW], want.begin_x);
                check_field("begin_y", m_tdata[3 * CW +: CW], want.begin_y);
                check_field("move_x", m_tdata[MX_LSB +: CW + 1], want.move_x);
                check_field("move_y", m_tdata[MY_LSB +: CW + 1], want.move_y);
                check_field("hold_ms", m_tdata[HOLD_LSB +: TW], want.hold_ms);
                check_field("event_ms", m_tdata[EVT_LSB +: TW], want.event_ms);
            end
        end
    end

    initial
    begin
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = recv_idle_on ? $urandom_range(0, 12) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        touch_phase   = TOUCH_IDLE;
        press_x       = '0;
        press_y       = '0;
        press_ms      = '0;
        drag_x        = '0;
        drag_y        = '0;
        tap_waiting   = 1'b0;
        tap_x         = '0;
        tap_y         = '0;
        tap_ms        = '0;
        last_event_ms = '0;
        lim_debounce  = tgr_pkg::DEBOUNCE_MS_RST;
        lim_long      = tgr_pkg::LONG_PRESS_MS_RST;
        lim_tap       = TAP_DIST_RST;
        lim_drag      = DRAG_DIST_RST;
        lim_swipe     = SWIPE_DIST_RST;
        lim_swipe_ms  = tgr_pkg::SWIPE_MAX_MS_RST;
        lim_dtap_ms   = tgr_pkg::DOUBLE_TAP_MS_RST;
        lim_dtap      = DOUBLE_TAP_DIST_RST;
        send_idle_on  = 1'b1;
        recv_idle_on  = 1'b1;
        prev_x        = 0;
        prev_y        = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_long_press_and_debounce();
        test_swipes();
        test_drag();
        test_taps();
        now_ms = 32'd6000;
        test_random_touches(300);

        apply_settings('0, '0, '0, '0, '0, '0, '0, '0);
        test_random_touches(120);

        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                       16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_random_touches(120);

        test_spare_registers();
        test_random_settings(4);
        test_timestamp_wrap();

        settle();
        repeat (8) @(posedge clk);
        $display("covered %0d touch samples and %0d gesture events", samples_sent, events_seen);
        $display("with %0d register writes over %0d threshold settings plus reset values",
                 reg_writes, settings_used);
        if (error_count == 0)
            $display("touch_gesture_recognizer_tb: clean");
        else
            $display("touch_gesture_recognizer_tb: errors");
        $finish;
    end
endmodule

>>> files.f
+incdir+hdl
hdl/tgr_pkg.sv
hdl/touch_gesture_recognizer.sv
hdl/tgr_checker.sv
verif/touch_gesture_recognizer_tb.sv
